// ----- rtl/core/cgl_pkg.sv -----
// Shared types, widths and register indexes for the color gradient lookup.
// Used by the channel interfaces and by every module of the block.
package cgl_pkg;

   localparam int CGL_MAX_STOPS = 7;

   localparam int SAMPLE_W   = 16;
   localparam int CHAN_W     = 8;
   localparam int CHANNELS   = 3;
   localparam int STOP_W     = 40;
   localparam int COUNT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;

   localparam int GAP_W    = SAMPLE_W + 1;
   localparam int DIFF_W   = CHAN_W + 1;
   localparam int NUM_W    = SAMPLE_W + CHAN_W + 1;
   localparam int NUMABS_W = NUM_W - 1;
   localparam int QUO_W    = CHAN_W + 1;
   localparam int RES_W    = QUO_W + 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_WORD_0 = 3'd1;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic                                direct;
      logic [GAP_W-1:0]                    gap;
      logic [CHANNELS-1:0][CHAN_W-1:0]     base;
      logic [CHANNELS-1:0][NUM_W-1:0]      num;
   } cgl_entry_type;

   function automatic logic [SAMPLE_W-1:0] stop_pos(input logic [STOP_W-1:0] word);
      return word[STOP_W-1 -: SAMPLE_W];
   endfunction

   function automatic logic [CHAN_W-1:0] stop_chan(input logic [STOP_W-1:0] word,
                                                   input logic [1:0] ch);
      logic [CHAN_W-1:0] c;
      case (ch)
         CH_RED:   c = word[23:16];
         CH_GREEN: c = word[15:8];
         default:  c = word[7:0];
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/cgl_ifs.sv -----
// Valid/ready channel interfaces of the color gradient lookup.
// Depends on cgl_pkg for field widths.
interface cgl_req_if import cgl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_value;
   modport source (output valid, sample_value, input ready);
   modport sink   (input valid, sample_value, output ready);
endinterface

interface cgl_rsp_if import cgl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface cgl_csr_if import cgl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/cgl_front.sv -----
// Front end: stop registers, stop search and numerator products.
// Depends on cgl_pkg and the request and register interfaces.
module cgl_front import cgl_pkg::*; #(
   parameter int MAX_STOPS = CGL_MAX_STOPS
) (
   input  logic          clock,
   input  logic          reset,
   cgl_req_if.sink       req_bus,
   cgl_csr_if.sink       csr_bus,
   input  logic          queue_full,
   output logic          push,
   output cgl_entry_type entry
);

   logic [COUNT_W-1:0] stop_count_ff;
   logic [STOP_W-1:0]  stop_word_ff [MAX_STOPS];

   logic               f1_valid_ff;
   logic               f1_hit_ff,    f1_hit_in;
   logic [SAMPLE_W-1:0] f1_sample_ff;
   logic [STOP_W-1:0]  f1_lo_ff,     f1_lo_in;
   logic [STOP_W-1:0]  f1_hi_ff,     f1_hi_in;

   logic               f2_valid_ff;
   cgl_entry_type      f2_entry_ff,  f2_entry_in;

   logic               advance;
   logic [COUNT_W-1:0] count_lim;

   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= '0;
         for (int k = 0; k < MAX_STOPS; k++) stop_word_ff[k] <= '0;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == CSR_STOP_COUNT) stop_count_ff <= csr_bus.data[COUNT_W-1:0];
         for (int k = 0; k < MAX_STOPS; k++) begin
            if (csr_bus.index == CSR_STOP_WORD_0 + CSR_IDX_W'(k))
               stop_word_ff[k] <= csr_bus.data[STOP_W-1:0];
         end
      end
   end

   assign advance       = !(f2_valid_ff && queue_full);
   assign req_bus.ready = advance && !reset;
   assign push          = f2_valid_ff && !queue_full;
   assign entry         = f2_entry_ff;

   assign count_lim = (stop_count_ff > COUNT_W'(MAX_STOPS)) ? COUNT_W'(MAX_STOPS)
                                                            : stop_count_ff;

   // The search runs from the top so that the lowest matching stop wins.
   always_comb begin
      f1_hit_in = 1'b0;
      f1_lo_in  = stop_word_ff[0];
      f1_hi_in  = stop_word_ff[0];
      for (int i = MAX_STOPS - 1; i >= 0; i--) begin
         if ((COUNT_W'(i) < count_lim) &&
             (req_bus.sample_value < stop_pos(stop_word_ff[i]))) begin
            f1_hit_in = 1'b1;
            f1_hi_in  = stop_word_ff[i];
            f1_lo_in  = stop_word_ff[(i > 0) ? i - 1 : 0];
         end
      end
   end

   always_comb begin
      logic signed [GAP_W-1:0]   dv;
      logic signed [GAP_W-1:0]   gap;
      logic signed [DIFF_W-1:0]  dc;
      logic signed [NUM_W:0]     prod;
      logic [CHAN_W-1:0]         c_lo;
      logic [CHAN_W-1:0]         c_hi;
      dv  = $signed({1'b0, f1_sample_ff}) - $signed({1'b0, stop_pos(f1_lo_ff)});
      gap = $signed({1'b0, stop_pos(f1_hi_ff)}) - $signed({1'b0, stop_pos(f1_lo_ff)});
      f2_entry_in.gap    = gap;
      f2_entry_in.direct = !f1_hit_ff || (gap == '0);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         c_lo = stop_chan(f1_lo_ff, 2'(ch));
         c_hi = stop_chan(f1_hi_ff, 2'(ch));
         dc   = $signed({1'b0, c_hi}) - $signed({1'b0, c_lo});
         prod = (NUM_W+1)'(dv) * (NUM_W+1)'(dc);
         f2_entry_in.num[ch] = prod[NUM_W-1:0];
         if (!f1_hit_ff)          f2_entry_in.base[ch] = '0;
         else if (gap == '0)      f2_entry_in.base[ch] = c_hi;
         else                     f2_entry_in.base[ch] = c_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= req_bus.valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_sample_ff <= req_bus.sample_value;
         f1_hit_ff    <= f1_hit_in;
         f1_lo_ff     <= f1_lo_in;
         f1_hi_ff     <= f1_hi_in;
         f2_entry_ff  <= f2_entry_in;
      end
   end

endmodule

// ----- rtl/core/cgl_queue.sv -----
// Short queue of classified words between the front and back ends.
// Depends on cgl_pkg for the entry type and depth.
module cgl_queue import cgl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cgl_entry_type entry_in,
   input  logic          pop,
   output cgl_entry_type head,
   output logic          full,
   output logic          empty
);

   cgl_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= entry_in;
   end

endmodule

// ----- rtl/core/cgl_back.sv -----
// Back end: pipelined restoring divider, one quotient bit per stage,
// followed by the channel add, saturation and the result register.
// Depends on cgl_pkg and the response interface.
module cgl_back import cgl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cgl_entry_type head,
   input  logic          empty,
   output logic          pop,
   cgl_rsp_if.source     rsp_bus
);

   typedef struct packed {
      logic [NUMABS_W-1:0] rem;
      logic [QUO_W-1:0]    quo;
      logic                neg;
      logic                ovf;
      logic [CHAN_W-1:0]   base;
   } cgl_lane_type;

   typedef struct packed {
      logic                               direct;
      logic [SAMPLE_W-1:0]                gabs;
      logic [CHANNELS-1:0] [$bits(cgl_lane_type)-1:0] lane;
   } cgl_stage_type;

   cgl_stage_type st_ff  [QUO_W+1];
   cgl_stage_type st_in  [QUO_W+1];
   logic          vld_ff [QUO_W+1];

   logic                            rsp_valid_ff;
   logic [CHANNELS-1:0][CHAN_W-1:0] color_ff, color_in;
   logic                            advance;

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign pop     = advance && !empty;

   // Quotients are formed on magnitudes so that they truncate toward zero.
   // A quotient of 2**QUO_W or more is only flagged; it saturates the result unless the entry is direct.
   always_comb begin
      logic signed [NUM_W-1:0] numv;
      logic signed [GAP_W-1:0] gapv;
      logic [NUM_W-1:0]        nabs;
      logic [GAP_W-1:0]        gabs;
      cgl_lane_type            ln;
      gapv = $signed(head.gap);
      gabs = gapv[GAP_W-1] ? GAP_W'(-gapv) : GAP_W'(gapv);
      st_in[0].direct = head.direct;
      st_in[0].gabs   = gabs[SAMPLE_W-1:0];
      for (int ch = 0; ch < CHANNELS; ch++) begin
         numv    = $signed(head.num[ch]);
         nabs    = numv[NUM_W-1] ? NUM_W'(-numv) : NUM_W'(numv);
         ln.rem  = nabs[NUMABS_W-1:0];
         ln.quo  = '0;
         ln.neg  = numv[NUM_W-1] ^ gapv[GAP_W-1];
         ln.ovf  = ({1'b0, nabs[NUMABS_W-1:0]} >= {gabs[SAMPLE_W-1:0], QUO_W'(0)});
         ln.base = head.base[ch];
         st_in[0].lane[ch] = ln;
      end
      for (int s = 1; s <= QUO_W; s++) begin
         logic [NUMABS_W-1:0] trial;
         st_in[s] = st_ff[s-1];
         trial = {(NUMABS_W-SAMPLE_W)'(0), st_ff[s-1].gabs} << (QUO_W - s);
         for (int ch = 0; ch < CHANNELS; ch++) begin
            ln = st_ff[s-1].lane[ch];
            if (ln.rem >= trial) begin
               ln.rem = ln.rem - trial;
               ln.quo[QUO_W-s] = 1'b1;
            end
            st_in[s].lane[ch] = ln;
         end
      end
   end

   always_comb begin
      cgl_lane_type            ln;
      logic signed [RES_W-1:0] qs;
      logic signed [RES_W-1:0] r;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         ln = st_ff[QUO_W].lane[ch];
         qs = ln.neg ? -$signed({2'b00, ln.quo}) : $signed({2'b00, ln.quo});
         r  = $signed({3'b000, ln.base}) + qs;
         if (st_ff[QUO_W].direct)  color_in[ch] = ln.base;
         else if (ln.ovf)          color_in[ch] = ln.neg ? '0 : '1;
         else if (r[RES_W-1])      color_in[ch] = '0;
         else if (r > RES_W'(255)) color_in[ch] = '1;
         else                      color_in[ch] = r[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QUO_W; s++) vld_ff[s] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= pop;
         for (int s = 1; s <= QUO_W; s++) vld_ff[s] <= vld_ff[s-1];
         rsp_valid_ff <= vld_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s <= QUO_W; s++) st_ff[s] <= st_in[s];
         color_ff <= color_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.red   = color_ff[CH_RED];
   assign rsp_bus.green = color_ff[CH_GREEN];
   assign rsp_bus.blue  = color_ff[CH_BLUE];

endmodule

// ----- rtl/core/color_gradient_lookup_top.sv -----
// Color gradient lookup: one sample word in, one RGB word out per clock when the response side does not stall.
// From acceptance at the first front stage, a sample passes the second front stage, the queue slot,
// the sign stage, nine divider stages and the result register.
// Throughput is one word per cycle while nothing stalls, set by the pipelined divider in the back end.
// Synchronous active-high reset clears all stop registers, the count and the queue.
module color_gradient_lookup_top import cgl_pkg::*; #(
   parameter int MAX_STOPS = CGL_MAX_STOPS
) (
   input  logic      clock,
   input  logic      reset,
   cgl_req_if.sink   req_bus,
   cgl_rsp_if.source rsp_bus,
   cgl_csr_if.sink   csr_bus
);

   cgl_entry_type push_entry;
   cgl_entry_type head;
   logic          push;
   logic          pop;
   logic          queue_full;
   logic          queue_empty;

   cgl_front #(.MAX_STOPS(MAX_STOPS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   cgl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .entry_in (push_entry),
      .pop      (pop),
      .head     (head),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   cgl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .empty   (queue_empty),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
